FILE: sv/ert_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ert_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam int RTT_W = 42;
   localparam int SUM_W = 64;
   localparam int MS_W  = 10;
   localparam logic [MS_W-1:0] MS_PER_SECOND = MS_W'(1000);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PING_IDENT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = CSR_IDX_W'(1);

   localparam logic [15:0] PING_IDENT_RESET = 16'd1;
   localparam logic [7:0]  TIMEOUT_RESET    = 8'd5;

   localparam logic [1:0] MODE_SEND  = 2'd0;
   localparam logic [1:0] MODE_REPLY = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic [2:0] STAT_SENT       = 3'd0;
   localparam logic [2:0] STAT_FULL       = 3'd1;
   localparam logic [2:0] STAT_MATCHED    = 3'd2;
   localparam logic [2:0] STAT_UNMATCHED  = 3'd3;
   localparam logic [2:0] STAT_TIMEOUT    = 3'd4;
   localparam logic [2:0] STAT_NO_TIMEOUT = 3'd5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now_seconds;
      logic [15:0] reply_ident;
      logic [15:0] reply_seq;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [15:0]      seq_number;
      logic [RTT_W-1:0] rtt_ms;
      logic [31:0]      sent_total;
      logic [31:0]      received_total;
      logic [RTT_W-1:0] min_rtt_ms;
      logic [RTT_W-1:0] max_rtt_ms;
      logic [SUM_W-1:0] sum_rtt_ms;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ident;
      logic [15:0] seq;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             wr_en;
      logic             set_en;
      logic [IDX_W-1:0] wr_idx;
      entry_type        wr_entry;
      logic             clr_en;
      logic [IDX_W-1:0] clr_idx;
   } tbl_ctl_type;

endpackage

`default_nettype wire

FILE: sv/echo_request_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The table is scanned one slot per cycle through a registered read port. One item is in flight
// at a time: a new start is taken only in idle. A matched reply then passes the multiply, sum and
// min/max states, and a tick ends with a flush state. Busy drops with the final result strobe,
// which the receiver cannot stall. Reset: synchronous; clears table valid bits, counters and
// statistics, and restores the sequence number, ping ident and timeout to their reset values;
// datapath registers are not reset.

module echo_request_tracker_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire ert_pkg::req_type                   req_item,
   output logic                                    rsp_valid,
   output ert_pkg::rsp_type                        rsp_item,
   input  wire logic                               csr_we,
   input  wire logic [ert_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ert_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH,
      S_MUL,
      S_SUM,
      S_MINMAX
   } state_type;

   state_type                        state_ff, state_in;
   ert_pkg::req_type                 req_ff, req_in;
   logic                             iss_ff, iss_in;
   logic [ert_pkg::IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                             chk_vld_ff, chk_vld_in;
   logic [ert_pkg::IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic [ert_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             pend_vld_ff, pend_vld_in;
   logic [15:0]                      pend_seq_ff, pend_seq_in;
   logic [31:0]                      age_ff, age_in;
   logic [ert_pkg::RTT_W-1:0]        rtt_ff, rtt_in;
   logic [15:0]                      next_seq_ff, next_seq_in;
   logic [31:0]                      sent_cnt_ff, sent_cnt_in;
   logic [31:0]                      recv_cnt_ff, recv_cnt_in;
   logic [ert_pkg::RTT_W-1:0]        min_ff, min_in;
   logic [ert_pkg::RTT_W-1:0]        max_ff, max_in;
   logic [ert_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [15:0]                      ping_ident_ff, ping_ident_in;
   logic [7:0]                       timeout_ff, timeout_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ert_pkg::rsp_type                 rsp_ff, rsp_in;

   ert_pkg::tbl_ctl_type             tbl_ctl;
   ert_pkg::entry_type               rd_entry;
   logic                             rd_active;
   logic [31:0]                      age;
   logic                             hit;
   logic                             scan_end;
   logic [ert_pkg::SUM_W:0]          sum_wide;
   logic [2:0]                       o_status;
   logic [15:0]                      o_seq;
   logic [ert_pkg::RTT_W-1:0]        o_rtt;
   logic                             o_last;

   ert_table u_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tbl_ctl),
      .rd_entry  (rd_entry),
      .rd_active (rd_active)
   );

   assign age      = req_ff.now_seconds - rd_entry.stamp;
   assign scan_end = chk_vld_ff && (chk_idx_ff == ert_pkg::LAST_IDX);
   assign sum_wide = {1'b0, sum_ff} + (ert_pkg::SUM_W + 1)'(rtt_ff);

   always_comb begin
      hit = 1'b0;
      if (chk_vld_ff) begin
         case (req_ff.mode)
            ert_pkg::MODE_SEND: begin
               hit = !rd_active;
            end
            ert_pkg::MODE_REPLY: begin
               hit = rd_active && (rd_entry.ident == req_ff.reply_ident)
                     && (rd_entry.seq == req_ff.reply_seq);
            end
            ert_pkg::MODE_TICK: begin
               hit = rd_active && (age > {24'd0, timeout_ff})
                     && (cnt_ff < ert_pkg::CNT_W'(ert_pkg::MAX_RESULTS));
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      iss_in        = iss_ff;
      rd_idx_in     = rd_idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      cnt_in        = cnt_ff;
      pend_vld_in   = pend_vld_ff;
      pend_seq_in   = pend_seq_ff;
      age_in        = age_ff;
      rtt_in        = rtt_ff;
      next_seq_in   = next_seq_ff;
      sent_cnt_in   = sent_cnt_ff;
      recv_cnt_in   = recv_cnt_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      sum_in        = sum_ff;
      ping_ident_in = ping_ident_ff;
      timeout_in    = timeout_ff;
      rsp_valid_in  = 1'b0;
      o_status      = ert_pkg::STAT_SENT;
      o_seq         = '0;
      o_rtt         = '0;
      o_last        = 1'b1;

      tbl_ctl          = '0;
      tbl_ctl.rd_en    = iss_ff;
      tbl_ctl.rd_idx   = rd_idx_ff;
      tbl_ctl.wr_idx   = chk_idx_ff;
      tbl_ctl.clr_idx  = chk_idx_ff;
      tbl_ctl.wr_entry = '{ident: ping_ident_ff, seq: next_seq_ff,
                           stamp: req_ff.now_seconds};

      if (csr_we) begin
         case (csr_index)
            ert_pkg::CSR_PING_IDENT: ping_ident_in = csr_wdata;
            ert_pkg::CSR_TIMEOUT:    timeout_in    = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.mode == ert_pkg::MODE_SEND || req_item.mode == ert_pkg::MODE_REPLY
                   || req_item.mode == ert_pkg::MODE_TICK) begin
                  state_in    = S_SCAN;
                  iss_in      = 1'b1;
                  rd_idx_in   = '0;
                  cnt_in      = '0;
                  pend_vld_in = 1'b0;
               end
            end
         end
         S_SCAN: begin
            // advance the read pointer one slot ahead of the check stage
            if (iss_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff;
               rd_idx_in  = rd_idx_ff + 1'b1;
               iss_in     = (rd_idx_ff != ert_pkg::LAST_IDX);
            end
            case (req_ff.mode)
               ert_pkg::MODE_SEND: begin
                  if (hit) begin
                     tbl_ctl.wr_en  = 1'b1;
                     tbl_ctl.set_en = (ping_ident_ff != 16'd0);
                     sent_cnt_in    = (sent_cnt_ff == '1) ? sent_cnt_ff : sent_cnt_ff + 1'b1;
                     next_seq_in    = next_seq_ff + 1'b1;
                     rsp_valid_in   = 1'b1;
                     o_status       = ert_pkg::STAT_SENT;
                     o_seq          = next_seq_ff;
                     state_in       = S_IDLE;
                     iss_in         = 1'b0;
                     chk_vld_in     = 1'b0;
                  end else if (scan_end) begin
                     rsp_valid_in = 1'b1;
                     o_status     = ert_pkg::STAT_FULL;
                     o_seq        = next_seq_ff;
                     state_in     = S_IDLE;
                  end
               end
               ert_pkg::MODE_REPLY: begin
                  if (hit) begin
                     tbl_ctl.clr_en = 1'b1;
                     age_in         = age;
                     state_in       = S_MUL;
                     iss_in         = 1'b0;
                     chk_vld_in     = 1'b0;
                  end else if (scan_end) begin
                     rsp_valid_in = 1'b1;
                     o_status     = ert_pkg::STAT_UNMATCHED;
                     o_seq        = req_ff.reply_seq;
                     state_in     = S_IDLE;
                  end
               end
               ert_pkg::MODE_TICK: begin
                  // hold each timeout one slot so the final one can carry last
                  if (hit) begin
                     tbl_ctl.clr_en = 1'b1;
                     cnt_in         = cnt_ff + 1'b1;
                     pend_vld_in    = 1'b1;
                     pend_seq_in    = rd_entry.seq;
                     if (pend_vld_ff) begin
                        rsp_valid_in = 1'b1;
                        o_status     = ert_pkg::STAT_TIMEOUT;
                        o_seq        = pend_seq_ff;
                        o_last       = 1'b0;
                     end
                  end
                  if (scan_end) begin
                     state_in = S_FLUSH;
                  end
               end
               default: begin
                  state_in = S_IDLE;
                  iss_in   = 1'b0;
               end
            endcase
         end
         S_FLUSH: begin
            rsp_valid_in = 1'b1;
            o_status     = pend_vld_ff ? ert_pkg::STAT_TIMEOUT : ert_pkg::STAT_NO_TIMEOUT;
            o_seq        = pend_vld_ff ? pend_seq_ff : 16'd0;
            pend_vld_in  = 1'b0;
            state_in     = S_IDLE;
         end
         S_MUL: begin
            rtt_in   = ert_pkg::RTT_W'(age_ff) * ert_pkg::RTT_W'(ert_pkg::MS_PER_SECOND);
            state_in = S_SUM;
         end
         S_SUM: begin
            recv_cnt_in = (recv_cnt_ff == '1) ? recv_cnt_ff : recv_cnt_ff + 1'b1;
            sum_in      = sum_wide[ert_pkg::SUM_W] ? '1 : sum_wide[ert_pkg::SUM_W-1:0];
            state_in    = S_MINMAX;
         end
         S_MINMAX: begin
            if (recv_cnt_ff == 32'd1) begin
               min_in = rtt_ff;
               max_in = rtt_ff;
            end else begin
               if (rtt_ff < min_ff) begin
                  min_in = rtt_ff;
               end
               if (rtt_ff > max_ff) begin
                  max_in = rtt_ff;
               end
            end
            rsp_valid_in = 1'b1;
            o_status     = ert_pkg::STAT_MATCHED;
            o_seq        = req_ff.reply_seq;
            o_rtt        = rtt_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in = '{status: o_status, seq_number: o_seq, rtt_ms: o_rtt,
                 sent_total: sent_cnt_in, received_total: recv_cnt_in,
                 min_rtt_ms: min_in, max_rtt_ms: max_in, sum_rtt_ms: sum_in,
                 last: o_last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         iss_ff        <= 1'b0;
         chk_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         next_seq_ff   <= 16'd1;
         sent_cnt_ff   <= '0;
         recv_cnt_ff   <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         sum_ff        <= '0;
         ping_ident_ff <= ert_pkg::PING_IDENT_RESET;
         timeout_ff    <= ert_pkg::TIMEOUT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_ff        <= iss_in;
         chk_vld_ff    <= chk_vld_in;
         pend_vld_ff   <= pend_vld_in;
         next_seq_ff   <= next_seq_in;
         sent_cnt_ff   <= sent_cnt_in;
         recv_cnt_ff   <= recv_cnt_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         sum_ff        <= sum_in;
         ping_ident_ff <= ping_ident_in;
         timeout_ff    <= timeout_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      chk_idx_ff  <= chk_idx_in;
      cnt_ff      <= cnt_in;
      pend_seq_ff <= pend_seq_in;
      age_ff      <= age_in;
      rtt_ff      <= rtt_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> $past(busy))
      else $error("result strobe without an item in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> !busy)
      else $error("still busy after final result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> busy && rsp_ff.status == ert_pkg::STAT_TIMEOUT)
      else $error("non-final result outside a timeout run");

   assert property (@(posedge clock) disable iff (reset) recv_cnt_ff <= sent_cnt_ff)
      else $error("more replies matched than requests sent");

   assert property (@(posedge clock) disable iff (reset) min_ff <= max_ff)
      else $error("minimum round trip above maximum");

endmodule

`default_nettype wire

FILE: sv/ert_table.sv
`timescale 1ns / 1ps
`default_nettype none

module ert_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ert_pkg::tbl_ctl_type  ctl,
   output ert_pkg::entry_type         rd_entry,
   output logic                       rd_active
);

   logic [ert_pkg::TABLE_ENTRIES-1:0] active_ff;
   logic [ert_pkg::TABLE_ENTRIES-1:0] active_in;
   ert_pkg::entry_type                mem [ert_pkg::TABLE_ENTRIES];
   ert_pkg::entry_type                rd_entry_ff;
   logic                              rd_active_ff;

   always_comb begin
      active_in = active_ff;
      if (ctl.wr_en) begin
         active_in[ctl.wr_idx] = ctl.set_en;
      end
      if (ctl.clr_en) begin
         active_in[ctl.clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_idx] <= ctl.wr_entry;
      end
      if (ctl.rd_en) begin
         rd_entry_ff  <= mem[ctl.rd_idx];
         rd_active_ff <= active_ff[ctl.rd_idx];
      end
   end

   assign rd_entry  = rd_entry_ff;
   assign rd_active = rd_active_ff;

endmodule

`default_nettype wire
